FILE: hdl/plm_pkg.sv
// ----------------------------------------------------------------------------
// Pulse length / period measurement: shared package
// Types, register indexes and fixed field widths of the measurement core.
// ----------------------------------------------------------------------------
package plm_pkg;

  // Fixed field widths
  localparam int LEN_W      = 27;  // length_us result field
  localparam int TIMEOUT_W  = 16;  // give-up time register, in milliseconds
  localparam int LIMIT_W    = 26;  // give-up time in microseconds fits in 26 bits
  localparam int CFG_IDX_W  = 2;

  localparam logic [LIMIT_W-1:0] US_PER_MS = LIMIT_W'(1000);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLARITY     = 2'd0,
    REG_MEASURE_MODE = 2'd1,
    REG_GIVE_UP      = 2'd2
  } cfg_reg_t;

  // Measurement input kinds
  typedef enum logic {
    ACT_START = 1'b0,
    ACT_TICK  = 1'b1
  } action_t;

  // Measurement phase
  typedef enum logic [1:0] {
    PH_WAIT_INACTIVE = 2'd0,
    PH_WAIT_START    = 2'd1,
    PH_IN_PULSE      = 2'd2,
    PH_WAIT_NEXT     = 2'd3
  } phase_t;

  // Mode encoding
  localparam logic MODE_LENGTH = 1'b1;

  // Reset values of the registers
  localparam logic                 POLARITY_RST = 1'b1;
  localparam logic                 MODE_RST     = 1'b1;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = TIMEOUT_W'(1000);

endpackage

FILE: hdl/pulse_length_or_period_measure_core.sv
// ----------------------------------------------------------------------------
// Pulse length / period measurement core
// Arms on a start word, follows one sampled pin on microsecond tick words and
// reports a pulse length or start-to-start period, or a timeout.
// ----------------------------------------------------------------------------
//
//   channel   | direction | payload                          | handshake
//   ----------+-----------+----------------------------------+-----------------
//   s_*       | in        | tuser: action, tdata[0]: level   | s_tvalid/s_tready
//   m_*       | out       | tdata[26:0]: length_us,          | m_tvalid/m_tready
//             |           | tuser: timed_out                 |
//   cfg_*     | in        | cfg_index, cfg_data[15:0]        | cfg_valid/cfg_ready
//
// One input word per cycle while s_tready is high: the phase update, counter
// step and result select sit between the measurement state registers and the
// output register. A result is registered there, or in the skid register.
// A two-entry output buffer (output register plus skid register) keeps
// s_tready high while one result waits; it drops only with both entries full.
// cfg_ready is always high. rst is synchronous and needs no clearing pass.
//
module pulse_length_or_period_measure_core #(
  parameter int COUNTER_WIDTH = 27
) (
  input  logic                        clk,
  input  logic                        rst,
  // input words
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [0] level, [7:1] zero
  input  logic                        s_tuser,   // [0] action
  // result words
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [31:0]                 m_tdata,   // [26:0] length_us, [31:27] zero
  output logic                        m_tuser,   // [0] timed_out
  // configuration writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [plm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                 cfg_data
);
  import plm_pkg::*;

  localparam int CW   = COUNTER_WIDTH;
  localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;

  // Configuration
  logic               polarity;
  logic               measure_mode;
  logic [LIMIT_W-1:0] limit_us;

  // Measurement state
  logic          armed, armed_next;
  phase_t        phase, phase_next;
  logic [CW-1:0] elapsed_us, elapsed_us_next;
  logic [CW-1:0] pulse_begin_us, pulse_begin_us_next;

  // Result of the current word
  logic             res_push;
  logic [LEN_W-1:0] res_len;
  logic             res_to;

  // Output buffer
  logic             out_valid, skid_valid;
  logic [LEN_W-1:0] out_len, skid_len;
  logic             out_to, skid_to;

  logic          in_fire, out_pop;
  logic          active;
  logic [CW-1:0] diff_us;
  logic [LEN_W-1:0] diff_len;
  logic          timeout_hit;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign in_fire   = s_tvalid && s_tready;
  assign out_pop   = out_valid && m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(32-LEN_W){1'b0}}, out_len};
  assign m_tuser  = out_to;

  // Register configuration writes; the limit is kept in microseconds
  always_ff @(posedge clk) begin
    if (rst) begin
      polarity     <= POLARITY_RST;
      measure_mode <= MODE_RST;
      limit_us     <= LIMIT_W'(TIMEOUT_RST) * US_PER_MS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POLARITY:     polarity     <= cfg_data[0];
        REG_MEASURE_MODE: measure_mode <= cfg_data[0];
        REG_GIVE_UP:      limit_us     <= LIMIT_W'(cfg_data) * US_PER_MS;
        default:          ;
      endcase
    end
  end

  // Length from pulse start, clamped to the result field
  assign diff_us = elapsed_us - pulse_begin_us;
  generate
    if (CW > LEN_W) begin : g_clamp
      assign diff_len = (|diff_us[CW-1:LEN_W]) ? {LEN_W{1'b1}} : diff_us[LEN_W-1:0];
    end else begin : g_ext
      assign diff_len = LEN_W'(diff_us);
    end
  endgenerate

  assign active      = (s_tdata[0] == polarity);
  assign timeout_hit = (CMPW'(elapsed_us) > CMPW'(limit_us)) || (&elapsed_us);

  // Phase update, counter step and result select for one word
  always_comb begin
    armed_next          = armed;
    phase_next          = phase;
    elapsed_us_next     = elapsed_us;
    pulse_begin_us_next = pulse_begin_us;
    res_push            = 1'b0;
    res_len             = '0;
    res_to              = 1'b0;
    if (in_fire) begin
      if (s_tuser == ACT_START) begin
        armed_next          = 1'b1;
        phase_next          = PH_WAIT_INACTIVE;
        elapsed_us_next     = '0;
        pulse_begin_us_next = '0;
      end else if (armed) begin
        if (!(&elapsed_us)) begin
          elapsed_us_next = elapsed_us + CW'(1);
        end
        case (phase)
          PH_WAIT_INACTIVE: begin
            if (!active) phase_next = PH_WAIT_START;
          end
          PH_WAIT_START: begin
            if (active) begin
              phase_next          = PH_IN_PULSE;
              pulse_begin_us_next = elapsed_us;
            end
          end
          PH_IN_PULSE: begin
            if (!active) begin
              if (measure_mode == MODE_LENGTH) begin
                res_push = 1'b1;
                res_len  = diff_len;
              end else begin
                phase_next = PH_WAIT_NEXT;
              end
            end
          end
          PH_WAIT_NEXT: begin
            if (active) begin
              res_push = 1'b1;
              res_len  = diff_len;
            end
          end
          default: phase_next = PH_WAIT_INACTIVE;
        endcase
        // Give up when the measurement has not finished in time
        if (!res_push && timeout_hit) begin
          res_push = 1'b1;
          res_len  = '0;
          res_to   = 1'b1;
        end
        if (res_push) armed_next = 1'b0;
      end
    end
  end

  // Hold measurement state
  always_ff @(posedge clk) begin
    if (rst) begin
      armed          <= 1'b0;
      phase          <= PH_WAIT_INACTIVE;
      elapsed_us     <= '0;
      pulse_begin_us <= '0;
    end else begin
      armed          <= armed_next;
      phase          <= phase_next;
      elapsed_us     <= elapsed_us_next;
      pulse_begin_us <= pulse_begin_us_next;
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (res_push) begin
      if (!out_valid || out_pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  // Move result payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_pop) begin
        out_len <= skid_len;
        out_to  <= skid_to;
      end
    end else if (res_push) begin
      if (!out_valid || out_pop) begin
        out_len <= res_len;
        out_to  <= res_to;
      end else begin
        skid_len <= res_len;
        skid_to  <= res_to;
      end
    end
  end

  // Skid entry is only used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a word while the output register is empty");

  // Any result ends the measurement
  a_result_disarms: assert property (@(posedge clk) disable iff (rst)
    res_push |=> !armed)
    else $error("measurement still armed after a result");

  // A start word restarts the time base
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tuser == ACT_START) |=> (armed && elapsed_us == '0))
    else $error("start word did not restart the measurement");

  // Timeout results carry zero length
  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_to) |-> (out_len == '0))
    else $error("timeout result with nonzero length");

  // No result without an armed tick
  a_result_needs_tick: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (in_fire && armed && s_tuser == ACT_TICK))
    else $error("result without an armed tick word");

endmodule
